@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the gemm tile rtl
// no dependencies; define NO_ASSERTIONS to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define GT_ASSERT(lbl, clk, rst, prop) lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m: check failed");
`define GT_NEVER(lbl, clk, rst, expr) lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error("%m: forbidden condition");
`else
`define GT_ASSERT(lbl, clk, rst, prop)
`define GT_NEVER(lbl, clk, rst, expr)
`endif
`endif

@@ hw/rtl/gtile_pkg.sv @@
// shared types, constants and helper functions for the gemm tile engine
// no dependencies
package gtile_pkg;

   localparam int TILE_ROWS_DEF = 8;
   localparam int TILE_COLS_DEF = 16;
   localparam int MAX_ELEMS     = 16;
   localparam int LANE_LAT      = 5;
   localparam int ROW_IDX_W     = 4;
   localparam int CNT_W         = 5;
   localparam int CSR_IDX_W     = 1;

   localparam logic [31:0] FP_QNAN     = 32'h7FC0_0000;
   localparam logic [31:0] FP_INF      = 32'h7F80_0000;
   localparam logic [31:0] FP_NEG_ZERO = 32'h8000_0000;
   localparam logic [31:0] ALPHA_RESET = 32'h3F80_0000;
   localparam logic [31:0] BETA_RESET  = 32'h0000_0000;

   localparam logic [1:0] FN_LOAD_A = 2'd0;
   localparam logic [1:0] FN_ACC    = 2'd1;
   localparam logic [1:0] FN_EPI    = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_BETA  = 1'b1;

   typedef logic signed [11:0] exp_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  row;
      logic [63:0] word0;
      logic [63:0] word1;
      logic [63:0] word2;
      logic [63:0] word3;
      logic [63:0] word4;
      logic [63:0] word5;
      logic [63:0] word6;
      logic [63:0] word7;
   } req_type;

   typedef struct packed {
      logic [2:0]  out_row;
      logic [63:0] out_word0;
      logic [63:0] out_word1;
      logic [63:0] out_word2;
      logic [63:0] out_word3;
      logic [63:0] out_word4;
      logic [63:0] out_word5;
      logic [63:0] out_word6;
      logic [63:0] out_word7;
      logic        tile_done;
   } rsp_type;

   typedef enum logic [1:0] {LSRC_ACC, LSRC_SCALE, LSRC_BETA} lane_src_type;

   typedef enum logic [1:0] {ST_IDLE, ST_ACC, ST_EPI_WAIT, ST_EPI} seq_state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [ROW_IDX_W-1:0] rd_row;
      lane_src_type         lane_src;
      logic [ROW_IDX_W-1:0] a_row;
      logic                 wr_en;
      logic [ROW_IDX_W-1:0] wr_row;
      logic                 out_load;
      logic                 tile_clear;
   } seq_cmd_type;

   function automatic logic [31:0] req_elem(req_type r, int unsigned idx);
      logic [63:0] w;
      begin
         case (idx >> 1)
            0: w = r.word0;
            1: w = r.word1;
            2: w = r.word2;
            3: w = r.word3;
            4: w = r.word4;
            5: w = r.word5;
            6: w = r.word6;
            7: w = r.word7;
            default: w = '0;
         endcase
         return idx[0] ? w[63:32] : w[31:0];
      end
   endfunction

   function automatic logic [6:0] lzc64(logic [63:0] v);
      logic [6:0] n;
      begin
         n = 7'd64;
         for (int i = 0; i < 64; i++) begin
            if (v[i]) n = 7'(63 - i);
         end
         return n;
      end
   endfunction

endpackage

@@ hw/rtl/gemm_tile_8x16_fp32.sv @@
// gemm tile engine: C = alpha*A*B + beta*C on an fp32 output tile
// depends on gtile_pkg, gtile_fma, gtile_acc_mem, gtile_seq, gtile_merge
//
// usage
//  - req channel (valid/ready): func 0 latches one column of A, func 1 carries
//    one row of B and accumulates the outer product, func 2 carries one old
//    row of C and returns the finished row on the rsp channel
//  - csr channel (valid/ready, always ready): index 0 alpha, index 1 beta;
//    write only while the block is idle
//  - one transfer on req at a time; a func 2 runs a second lane pass when
//    beta is nonzero; the timing comes from the five-stage fma lanes, which
//    sweep one tile row per cycle, and the single accumulator read port
//  - rsp data sits in an output register; if the receiver stalls, new func 0
//    and func 1 transfers still go ahead and a func 2 waits before its first
//    read until the register is free
//  - reset: alpha = 1.0, beta = +0, accumulators read as +0 at once through
//    row valid bits; they clear again when the last tile row is loaded into the output register
//  - func 3 and a func 2 row outside the tile are taken and dropped
module gemm_tile_8x16_fp32 #(
   parameter int TILE_ROWS = gtile_pkg::TILE_ROWS_DEF,
   parameter int TILE_COLS = gtile_pkg::TILE_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  gtile_pkg::req_type             req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output gtile_pkg::rsp_type             rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gtile_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_data
);
   import gtile_pkg::*;

   localparam int ROW_W = (TILE_ROWS > 1) ? $clog2(TILE_ROWS) : 1;

   // configuration registers
   logic [31:0] alpha_ff, beta_ff;
   logic        csr_fire;

   assign csr_ready = 1'b1;
   assign csr_fire  = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
         beta_ff  <= BETA_RESET;
      end else if (csr_fire) begin
         case (csr_index)
            CSR_ALPHA: alpha_ff <= csr_data;
            CSR_BETA:  beta_ff  <= csr_data;
            default:   alpha_ff <= alpha_ff;
         endcase
      end
   end

   // input transfer, item register and the A column
   logic        req_fire, seq_idle;
   req_type     item_ff;
   logic [31:0] in_elem   [MAX_ELEMS];
   logic [31:0] item_elem [MAX_ELEMS];
   logic [31:0] a_col_ff  [TILE_ROWS];

   assign req_ready = seq_idle;
   assign req_fire  = req_valid && req_ready;

   for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_elem
      assign in_elem[i]   = req_elem(req_data, i);
      assign item_elem[i] = req_elem(item_ff, i);
   end

   always_ff @(posedge clock) begin
      if (req_fire) item_ff <= req_data;
      if (req_fire && req_data.func == FN_LOAD_A) begin
         for (int r = 0; r < TILE_ROWS; r++) a_col_ff[r] <= in_elem[r];
      end
   end

   // sequencer
   seq_cmd_type cmd;
   logic        out_busy;

   gtile_seq #(.ROWS(TILE_ROWS)) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .func     (req_data.func),
      .row      (req_data.row),
      .beta_nz  (beta_ff[30:0] != 31'd0),
      .out_busy (out_busy),
      .idle     (seq_idle),
      .cmd      (cmd)
   );

   // accumulator rows
   logic [TILE_COLS*32-1:0] acc_rd, lane_flat;

   gtile_acc_mem #(.ROWS(TILE_ROWS), .COLS(TILE_COLS)) u_acc (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (cmd.rd_en),
      .rd_row    (cmd.rd_row),
      .wr_en     (cmd.wr_en),
      .wr_row    (cmd.wr_row),
      .wr_data   (lane_flat),
      .clear_all (cmd.tile_clear),
      .rd_data   (acc_rd)
   );

   // one fma lane per tile column; operands picked by the current pass
   logic [31:0] a_sel;

   assign a_sel = a_col_ff[cmd.a_row[ROW_W-1:0]];

   for (genvar c = 0; c < TILE_COLS; c++) begin : g_lane
      logic [31:0] op_a, op_b, op_c, res;

      always_comb begin
         case (cmd.lane_src)
            LSRC_ACC: begin
               op_a = a_sel;
               op_b = item_elem[c];
               op_c = acc_rd[c*32 +: 32];
            end
            LSRC_SCALE: begin
               // alpha * acc, added to -0 so the sign of a zero product survives
               op_a = alpha_ff;
               op_b = acc_rd[c*32 +: 32];
               op_c = FP_NEG_ZERO;
            end
            LSRC_BETA: begin
               op_a = beta_ff;
               op_b = item_elem[c];
               op_c = res;
            end
            default: begin
               op_a = a_sel;
               op_b = item_elem[c];
               op_c = acc_rd[c*32 +: 32];
            end
         endcase
      end

      gtile_fma u_fma (
         .clock  (clock),
         .op_a   (op_a),
         .op_b   (op_b),
         .op_c   (op_c),
         .result (res)
      );

      assign lane_flat[c*32 +: 32] = res;
   end

   // merging stage and output register
   gtile_merge #(.COLS(TILE_COLS)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (cmd.out_load),
      .last      (cmd.tile_clear),
      .row       (item_ff.row),
      .lane_res  (lane_flat),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .busy      (out_busy)
   );

endmodule

@@ hw/rtl/gtile_fma.sv @@
// one fp32 fused multiply-add lane, five register stages, round to nearest even
// depends on gtile_pkg
module gtile_fma (
   input  logic        clock,
   input  logic [31:0] op_a,
   input  logic [31:0] op_b,
   input  logic [31:0] op_c,
   output logic [31:0] result
);
   import gtile_pkg::*;

   // stage 1: unpack, special values, mantissa product
   logic        sa, sb, sc, sp, za, zb, zc, nan_in;
   logic [7:0]  ea, eb, ec, ea1, eb1, ec1;
   logic [22:0] fa, fb, fc;
   logic [23:0] ma, mb;
   logic        s1_spec_in;
   logic [31:0] s1_sval_in;
   logic [47:0] prod_in;
   exp_type     ep_raw_in, ecx_raw_in;

   always_comb begin
      sa = op_a[31];
      sb = op_b[31];
      sc = op_c[31];
      sp = sa ^ sb;
      ea = op_a[30:23];
      eb = op_b[30:23];
      ec = op_c[30:23];
      fa = op_a[22:0];
      fb = op_b[22:0];
      fc = op_c[22:0];
      za = (op_a[30:0] == 31'd0);
      zb = (op_b[30:0] == 31'd0);
      zc = (op_c[30:0] == 31'd0);
      nan_in = (ea == 8'hFF && fa != 23'd0) || (eb == 8'hFF && fb != 23'd0) ||
               (ec == 8'hFF && fc != 23'd0);
      s1_spec_in = 1'b1;
      s1_sval_in = FP_QNAN;
      if (nan_in) begin
         s1_sval_in = FP_QNAN;
      end else if (ea == 8'hFF || eb == 8'hFF) begin
         if (za || zb) s1_sval_in = FP_QNAN;
         else if (ec == 8'hFF && sc != sp) s1_sval_in = FP_QNAN;
         else s1_sval_in = {sp, FP_INF[30:0]};
      end else if (ec == 8'hFF) begin
         s1_sval_in = op_c;
      end else if (za || zb) begin
         if (zc) s1_sval_in = (sp == sc) ? {sp, 31'd0} : 32'd0;
         else s1_sval_in = op_c;
      end else begin
         s1_spec_in = 1'b0;
      end
      ea1 = (ea != 8'd0) ? ea : 8'd1;
      eb1 = (eb != 8'd0) ? eb : 8'd1;
      ec1 = (ec != 8'd0) ? ec : 8'd1;
      ma = {ea != 8'd0, fa};
      mb = {eb != 8'd0, fb};
      ep_raw_in  = $signed({4'b0000, ea1}) + $signed({4'b0000, eb1}) - 12'sd300;
      ecx_raw_in = $signed({4'b0000, ec1}) - 12'sd150;
   end

   assign prod_in = ma * mb;

   logic        s1_spec_ff, s1_sp_ff, s1_sc_ff, s1_zc_ff;
   logic [31:0] s1_sval_ff;
   logic [47:0] s1_p_ff;
   logic [23:0] s1_mc_ff;
   exp_type     s1_ep_ff, s1_ecx_ff;

   always_ff @(posedge clock) begin
      s1_spec_ff <= s1_spec_in;
      s1_sval_ff <= s1_sval_in;
      s1_sp_ff   <= sp;
      s1_sc_ff   <= sc;
      s1_zc_ff   <= zc;
      s1_p_ff    <= prod_in;
      s1_mc_ff   <= {ec != 8'd0, fc};
      s1_ep_ff   <= ep_raw_in;
      s1_ecx_ff  <= ecx_raw_in;
   end

   // stage 2: normalise both operands to bit 62, order them
   logic [63:0] v_p, v_c, mp, mcn;
   logic [6:0]  lz_p, lz_c;
   exp_type     ep, ecx, dd;
   logic        prod_big;
   logic [63:0] s2_big_in, s2_small_in;
   exp_type     s2_e_in;
   logic [6:0]  s2_d_in;
   logic        s2_sign_in, s2_sub_in;

   always_comb begin
      v_p  = {1'b0, s1_p_ff, 15'd0};
      lz_p = lzc64(v_p);
      mp   = v_p << (lz_p - 7'd1);
      ep   = s1_ep_ff - $signed({5'd0, lz_p}) - 12'sd14;
      v_c  = {1'b0, s1_mc_ff, 39'd0};
      lz_c = lzc64(v_c);
      mcn  = v_c << (lz_c - 7'd1);
      ecx  = s1_ecx_ff - $signed({5'd0, lz_c}) - 12'sd38;
      prod_big    = s1_zc_ff || (ep > ecx) || (ep == ecx && mp >= mcn);
      s2_big_in   = prod_big ? mp : mcn;
      s2_small_in = s1_zc_ff ? 64'd0 : (prod_big ? mcn : mp);
      s2_e_in     = prod_big ? ep : ecx;
      dd          = prod_big ? (ep - ecx) : (ecx - ep);
      if (s1_zc_ff) s2_d_in = 7'd0;
      else if (dd > 12'sd63) s2_d_in = 7'd63;
      else s2_d_in = dd[6:0];
      s2_sign_in = prod_big ? s1_sp_ff : s1_sc_ff;
      s2_sub_in  = !s1_zc_ff && (s1_sp_ff != s1_sc_ff);
   end

   logic        s2_spec_ff, s2_sign_ff, s2_sub_ff;
   logic [31:0] s2_sval_ff;
   logic [63:0] s2_big_ff, s2_small_ff;
   exp_type     s2_e_ff;
   logic [6:0]  s2_d_ff;

   always_ff @(posedge clock) begin
      s2_spec_ff  <= s1_spec_ff;
      s2_sval_ff  <= s1_sval_ff;
      s2_big_ff   <= s2_big_in;
      s2_small_ff <= s2_small_in;
      s2_e_ff     <= s2_e_in;
      s2_d_ff     <= s2_d_in;
      s2_sign_ff  <= s2_sign_in;
      s2_sub_ff   <= s2_sub_in;
   end

   // stage 3: align with sticky, add or subtract
   logic [63:0] mask, small_al, sum_in;

   always_comb begin
      mask = (64'd1 << s2_d_ff) - 64'd1;
      if (s2_d_ff >= 7'd63) small_al = 64'd1;
      else small_al = (s2_small_ff >> s2_d_ff) | {63'd0, |(s2_small_ff & mask)};
      sum_in = s2_sub_ff ? (s2_big_ff - small_al) : (s2_big_ff + small_al);
   end

   logic        s3_spec_ff, s3_sign_ff;
   logic [31:0] s3_sval_ff;
   logic [63:0] s3_m_ff;
   exp_type     s3_e_ff;

   always_ff @(posedge clock) begin
      s3_spec_ff <= s2_spec_ff;
      s3_sval_ff <= s2_sval_ff;
      s3_sign_ff <= s2_sign_ff;
      s3_m_ff    <= sum_in;
      s3_e_ff    <= s2_e_ff;
   end

   // stage 4: leading one, target exponent and rounding position
   logic [6:0] lz_m;
   exp_type    ex, eff_in, sh_in;
   logic       s4_spec_in;
   logic [31:0] s4_sval_in;

   always_comb begin
      lz_m   = lzc64(s3_m_ff);
      ex     = s3_e_ff - $signed({5'd0, lz_m}) + 12'sd190;
      eff_in = (ex < 12'sd1) ? 12'sd1 : ex;
      sh_in  = eff_in - 12'sd150 - s3_e_ff;
      s4_spec_in = s3_spec_ff || (s3_m_ff == 64'd0);
      s4_sval_in = s3_spec_ff ? s3_sval_ff : 32'd0;
   end

   logic        s4_spec_ff, s4_sign_ff, s4_ovf_ff;
   logic [31:0] s4_sval_ff;
   logic [63:0] s4_m_ff;
   exp_type     s4_eff_ff, s4_sh_ff;

   always_ff @(posedge clock) begin
      s4_spec_ff <= s4_spec_in;
      s4_sval_ff <= s4_sval_in;
      s4_sign_ff <= s3_sign_ff;
      s4_ovf_ff  <= (ex >= 12'sd255);
      s4_m_ff    <= s3_m_ff;
      s4_eff_ff  <= eff_in;
      s4_sh_ff   <= sh_in;
   end

   // stage 5: shift into place, round, pack
   exp_type      neg_sh;
   logic [6:0]   shc;
   logic [127:0] wide;
   logic [63:0]  hi, lo, left;
   logic         rnd;
   logic [24:0]  mant;
   logic [7:0]   eff8;
   logic [31:0]  bits, res_in;

   always_comb begin
      neg_sh = -s4_sh_ff;
      shc    = (s4_sh_ff > 12'sd127) ? 7'd127 : s4_sh_ff[6:0];
      wide   = {s4_m_ff, 64'd0} >> shc;
      hi     = wide[127:64];
      lo     = wide[63:0];
      left   = s4_m_ff << neg_sh[5:0];
      rnd    = lo[63] && ((|lo[62:0]) || hi[0]);
      if (s4_sh_ff <= 12'sd0) mant = left[24:0];
      else mant = hi[24:0] + {24'd0, rnd};
      eff8 = s4_eff_ff[7:0] - 8'd1;
      bits = {1'b0, eff8, 23'd0} + {7'd0, mant};
      if (bits >= FP_INF || s4_ovf_ff) bits = FP_INF;
      res_in = s4_spec_ff ? s4_sval_ff : {s4_sign_ff, bits[30:0]};
   end

   logic [31:0] res_ff;

   always_ff @(posedge clock) begin
      res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

@@ hw/rtl/gtile_acc_mem.sv @@
// accumulator store: one row of lane values per entry, row valid bits for clear
// depends on gtile_pkg
module gtile_acc_mem #(
   parameter int ROWS = gtile_pkg::TILE_ROWS_DEF,
   parameter int COLS = gtile_pkg::TILE_COLS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           rd_en,
   input  logic [gtile_pkg::ROW_IDX_W-1:0] rd_row,
   input  logic                           wr_en,
   input  logic [gtile_pkg::ROW_IDX_W-1:0] wr_row,
   input  logic [COLS*32-1:0]             wr_data,
   input  logic                           clear_all,
   output logic [COLS*32-1:0]             rd_data
);
   import gtile_pkg::*;

   localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [COLS*32-1:0] mem_ff [ROWS];
   logic [COLS*32-1:0] rd_data_ff;
   logic [ROWS-1:0]    valid_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_row[ROW_W-1:0]] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_row[ROW_W-1:0]];
   end

   // a row never written since the last clear reads as +0
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (clear_all) valid_ff <= '0;
         else if (wr_en) valid_ff[wr_row[ROW_W-1:0]] <= 1'b1;
         if (rd_en) rd_valid_ff <= valid_ff[rd_row[ROW_W-1:0]];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ hw/rtl/gtile_seq.sv @@
// sequencer: steps the lanes through the tile rows and the epilogue passes
// depends on gtile_pkg and assert_macros.svh
`include "assert_macros.svh"
module gtile_seq #(
   parameter int ROWS = gtile_pkg::TILE_ROWS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [1:0]             func,
   input  logic [2:0]             row,
   input  logic                   beta_nz,
   input  logic                   out_busy,
   output logic                   idle,
   output gtile_pkg::seq_cmd_type cmd
);
   import gtile_pkg::*;

   localparam logic [CNT_W-1:0]       ROWS_C   = CNT_W'(ROWS);
   localparam logic [CNT_W-1:0]       ACC_LAST = CNT_W'(ROWS + LANE_LAT);
   localparam logic [CNT_W-1:0]       P1_DONE  = CNT_W'(LANE_LAT + 1);
   localparam logic [CNT_W-1:0]       P2_DONE  = CNT_W'(2 * LANE_LAT + 1);
   localparam logic [ROW_IDX_W:0]     ROWS_V   = (ROW_IDX_W + 1)'(ROWS);
   localparam logic [ROW_IDX_W-1:0]   LAST_ROW = ROW_IDX_W'(ROWS - 1);

   seq_state_type        state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in, cnt_m1, cnt_wb;
   logic [ROW_IDX_W-1:0] row_ff, row_in;
   logic                 row_ok;

   assign row_ok = ({2'b00, row} < ROWS_V);
   assign cnt_m1 = cnt_ff - CNT_W'(1);
   assign cnt_wb = cnt_ff - P1_DONE;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + CNT_W'(1);
      row_in   = row_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (start) begin
               row_in = {1'b0, row};
               if (func == FN_ACC) state_in = ST_ACC;
               else if (func == FN_EPI && row_ok) state_in = ST_EPI_WAIT;
            end
         end
         ST_ACC: begin
            if (cnt_ff == ACC_LAST) state_in = ST_IDLE;
         end
         ST_EPI_WAIT: begin
            cnt_in = '0;
            if (!out_busy) state_in = ST_EPI;
         end
         ST_EPI: begin
            if ((cnt_ff == P1_DONE && !beta_nz) || cnt_ff == P2_DONE) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.lane_src = LSRC_ACC;
      case (state_ff)
         ST_ACC: begin
            cmd.rd_en  = (cnt_ff < ROWS_C);
            cmd.rd_row = cnt_ff[ROW_IDX_W-1:0];
            cmd.a_row  = cnt_m1[ROW_IDX_W-1:0];
            cmd.wr_en  = (cnt_ff >= P1_DONE);
            cmd.wr_row = cnt_wb[ROW_IDX_W-1:0];
         end
         ST_EPI: begin
            cmd.rd_en  = (cnt_ff == '0);
            cmd.rd_row = row_ff;
            if (cnt_ff == CNT_W'(1)) cmd.lane_src = LSRC_SCALE;
            if (cnt_ff == P1_DONE) begin
               if (beta_nz) cmd.lane_src = LSRC_BETA;
               else cmd.out_load = 1'b1;
            end
            if (cnt_ff == P2_DONE) cmd.out_load = 1'b1;
            cmd.tile_clear = cmd.out_load && (row_ff == LAST_ROW);
         end
         default: cmd.lane_src = LSRC_ACC;
      endcase
   end

   assign idle = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         row_ff   <= row_in;
      end
   end

   `GT_NEVER(a_rd_wr_same_row, clock, reset, cmd.rd_en && cmd.wr_en && (cmd.rd_row == cmd.wr_row))
   `GT_NEVER(a_load_when_busy, clock, reset, cmd.out_load && out_busy)
   `GT_ASSERT(a_clear_with_load, clock, reset, cmd.tile_clear |-> cmd.out_load)
   `GT_ASSERT(a_acc_start, clock, reset, (state_ff == ST_IDLE && start && func == FN_ACC) |=> (state_ff == ST_ACC))

endmodule

@@ hw/rtl/gtile_merge.sv @@
// merging stage: gathers the lane results of one row into the response register
// depends on gtile_pkg
module gtile_merge #(
   parameter int COLS = gtile_pkg::TILE_COLS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  logic               last,
   input  logic [2:0]         row,
   input  logic [COLS*32-1:0] lane_res,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output gtile_pkg::rsp_type rsp_data,
   output logic               busy
);
   import gtile_pkg::*;

   logic [MAX_ELEMS*32-1:0] flat;
   rsp_type                 rsp_in, rsp_ff;
   logic                    valid_ff;

   always_comb begin
      flat = '0;
      flat[COLS*32-1:0] = lane_res;
      rsp_in.out_row   = row;
      rsp_in.out_word0 = flat[63:0];
      rsp_in.out_word1 = flat[127:64];
      rsp_in.out_word2 = flat[191:128];
      rsp_in.out_word3 = flat[255:192];
      rsp_in.out_word4 = flat[319:256];
      rsp_in.out_word5 = flat[383:320];
      rsp_in.out_word6 = flat[447:384];
      rsp_in.out_word7 = flat[511:448];
      rsp_in.tile_done = last;
   end

   always_ff @(posedge clock) begin
      if (load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (load) valid_ff <= 1'b1;
      else if (rsp_ready) valid_ff <= 1'b0;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = rsp_ff;
   assign busy      = valid_ff;

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the gemm_tile_8x16_fp32 output-tile engine
// needs gtile_pkg and the tile rtl; predicts every returned row with its own fp32 fma model
`timescale 1ns / 1ps

module testbench;
   import gtile_pkg::*;

   localparam int ROWS = 8;
   localparam int COLS = 16;
   localparam logic [1:0] FN_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 20000;   // cycles with no transfer before giving up
   localparam int DRAIN_CYCLES = 40;    // covers the longest func 1 sweep
   localparam int HOLD_CYCLES = 1500;   // long receiver hold-off

   typedef logic [31:0] vec16_type [COLS];

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [31:0]          csr_data;

   // model state, updated on each accepted transfer
   logic [31:0] a_col_m [ROWS];
   logic [31:0] acc_m [ROWS*COLS];
   logic [31:0] alpha_m;
   logic [31:0] beta_m;

   rsp_type     row_results_q [$];
   int          err_count;
   int          transfers;
   int          items_sent;
   int          rows_checked;
   int          hold_req;
   bit          no_idle;

   gemm_tile_8x16_fp32 dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- fp32 arithmetic

   function automatic int msb_of(logic [63:0] v);
      int n;
      n = -1;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) n = i;
      end
      return n;
   endfunction

   // round sign * m * 2^e to single precision, nearest-even, subnormals kept
   function automatic logic [31:0] fp_round(logic sign, logic [63:0] m, int e);
      int          ex;
      int          eff;
      int          sh;
      logic [63:0] mant;
      logic [63:0] rem;
      logic [63:0] half;
      logic [63:0] bits;
      ex = e + msb_of(m) + 127;
      if (ex >= 255) return {sign, 8'hFF, 23'h0};
      eff = (ex < 1) ? 1 : ex;
      sh = eff - 150 - e;
      if (sh <= 0) begin
         mant = m << (-sh);
      end else if (sh >= 64) begin
         mant = (sh == 64 && m > 64'h8000_0000_0000_0000) ? 64'd1 : 64'd0;
      end else begin
         rem  = m & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         mant = m >> sh;
         if (rem > half || (rem == half && mant[0])) mant = mant + 64'd1;
      end
      bits = (64'(eff - 1) << 23) + mant;
      if (bits >= 64'(FP_INF)) bits = 64'(FP_INF);
      return {sign, bits[30:0]};
   endfunction

   // round(a*b + c) with a single rounding
   function automatic logic [31:0] fp_fma(logic [31:0] a, logic [31:0] b, logic [31:0] c);
      logic        sp;
      logic [7:0]  ea, eb, ec;
      logic        za, zb, zc;
      logic        nan_in;
      logic [63:0] p, mp, mc, big, sml, m, lost;
      int          ep, ecx, ebig, esml, d, s;
      logic        sbig, ssml;
      ea = a[30:23];
      eb = b[30:23];
      ec = c[30:23];
      sp = a[31] ^ b[31];
      za = (a[30:0] == 0);
      zb = (b[30:0] == 0);
      zc = (c[30:0] == 0);
      nan_in = (ea == 8'hFF && a[22:0] != 0) || (eb == 8'hFF && b[22:0] != 0) ||
               (ec == 8'hFF && c[22:0] != 0);
      if (nan_in) return FP_QNAN;
      if (ea == 8'hFF || eb == 8'hFF) begin
         // inf times zero, or inf meeting inf of the other sign
         if (za || zb) return FP_QNAN;
         if (ec == 8'hFF && c[31] != sp) return FP_QNAN;
         return {sp, 8'hFF, 23'h0};
      end
      if (ec == 8'hFF) return c;
      p  = 64'({ea != 0, a[22:0]}) * 64'({eb != 0, b[22:0]});
      ep = ((ea != 0) ? int'(ea) : 1) + ((eb != 0) ? int'(eb) : 1) - 300;
      if (p == 0) begin
         if (zc) return (sp == c[31]) ? {sp, 31'h0} : 32'h0;
         return c;
      end
      s  = 62 - msb_of(p);
      mp = p << s;
      ep = ep - s;
      if (zc) return fp_round(sp, mp, ep);
      mc  = 64'({ec != 0, c[22:0]});
      ecx = ((ec != 0) ? int'(ec) : 1) - 150;
      s   = 62 - msb_of(mc);
      mc  = mc << s;
      ecx = ecx - s;
      if (ep > ecx || (ep == ecx && mp >= mc)) begin
         big = mp; ebig = ep; sbig = sp;
         sml = mc; esml = ecx; ssml = c[31];
      end else begin
         big = mc; ebig = ecx; sbig = c[31];
         sml = mp; esml = ep; ssml = sp;
      end
      d = ebig - esml;
      if (d >= 63) begin
         sml = 64'd1;
      end else if (d > 0) begin
         lost = sml & ((64'd1 << d) - 64'd1);
         sml  = (sml >> d) | 64'(lost != 0);
      end
      m = (sbig == ssml) ? big + sml : big - sml;
      if (m == 0) return 32'h0;   // exact cancellation gives +0
      return fp_round(sbig, m, ebig);
   endfunction

   // ---------------------------------------------------------------- tile model

   function automatic logic [31:0] elem_of(req_type r, int idx);
      logic [63:0] w;
      case (idx >> 1)
         0: w = r.word0;
         1: w = r.word1;
         2: w = r.word2;
         3: w = r.word3;
         4: w = r.word4;
         5: w = r.word5;
         6: w = r.word6;
         default: w = r.word7;
      endcase
      return idx[0] ? w[63:32] : w[31:0];
   endfunction

   // advance the model by one accepted item, queue the row it returns
   task automatic tile_model_step(req_type it);
      logic [31:0] t [COLS];
      rsp_type     want;
      case (it.func)
         FN_LOAD_A: begin
            for (int r = 0; r < ROWS; r++) a_col_m[r] = elem_of(it, r);
         end
         FN_ACC: begin
            for (int r = 0; r < ROWS; r++)
               for (int c = 0; c < COLS; c++)
                  acc_m[r*COLS+c] = fp_fma(a_col_m[r], elem_of(it, c), acc_m[r*COLS+c]);
         end
         FN_EPI: begin
            for (int c = 0; c < COLS; c++) begin
               t[c] = fp_fma(alpha_m, acc_m[int'(it.row)*COLS+c], FP_NEG_ZERO);
               // beta of either zero sign drops the old row
               if (beta_m[30:0] != 0) t[c] = fp_fma(beta_m, elem_of(it, c), t[c]);
            end
            want.out_row   = it.row;
            want.out_word0 = {t[1], t[0]};
            want.out_word1 = {t[3], t[2]};
            want.out_word2 = {t[5], t[4]};
            want.out_word3 = {t[7], t[6]};
            want.out_word4 = {t[9], t[8]};
            want.out_word5 = {t[11], t[10]};
            want.out_word6 = {t[13], t[12]};
            want.out_word7 = {t[15], t[14]};
            want.tile_done = (it.row == 3'(ROWS - 1));
            row_results_q.push_back(want);
            if (want.tile_done)
               for (int i = 0; i < ROWS*COLS; i++) acc_m[i] = 32'h0;
         end
         default: ;   // unused func: dropped
      endcase
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic [31:0] rand_fp();
      logic s;
      s = 1'($urandom);
      case ($urandom_range(0, 15))
         0: return {s, 31'h0};
         1: return {s, 8'hFF, 23'h0};
         2: return {s, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
         3: return {s, 8'h00, 23'($urandom)};
         4: return {s, 8'hFE, 23'h7F_FFFF};
         5: return $urandom;
         default: return {s, 8'($urandom_range(118, 136)), 23'($urandom)};
      endcase
   endfunction

   function automatic vec16_type rand_vec();
      vec16_type v;
      for (int i = 0; i < COLS; i++) v[i] = rand_fp();
      return v;
   endfunction

   function automatic req_type make_req(logic [1:0] fn, logic [2:0] row, vec16_type v);
      req_type r;
      r.func  = fn;
      r.row   = row;
      r.word0 = {v[1], v[0]};
      r.word1 = {v[3], v[2]};
      r.word2 = {v[5], v[4]};
      r.word3 = {v[7], v[6]};
      r.word4 = {v[9], v[8]};
      r.word5 = {v[11], v[10]};
      r.word6 = {v[13], v[12]};
      r.word7 = {v[15], v[14]};
      return r;
   endfunction

   // one req transfer; caller is at a falling edge
   task automatic send_item(req_type it);
      int gap;
      gap = 0;
      if (!no_idle && $urandom_range(0, 99) < 30)
         gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      repeat (gap) @(negedge clock);
      req_data  = it;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      tile_model_step(it);
      transfers++;
      items_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic wait_drained();
      while (row_results_q.size() != 0) @(negedge clock);
      // a func 1 sweep may still be running with nothing queued
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      wait_drained();
      csr_index = idx;
      csr_data  = value;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ALPHA) alpha_m = value;
      else beta_m = value;
      transfers++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // a well-formed tile with random content, with some noise mixed in
   task automatic run_tile();
      int        ksteps;
      int        order [ROWS-1];
      int        j, tmp;
      vec16_type v;
      no_idle = ($urandom_range(0, 4) == 0);
      ksteps  = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 3);
      for (int k = 0; k < ksteps; k++) begin
         send_item(make_req(FN_LOAD_A, 3'($urandom), rand_vec()));
         if ($urandom_range(0, 9) == 0)
            send_item(make_req(FN_UNUSED, 3'($urandom), rand_vec()));
         send_item(make_req(FN_ACC, 3'($urandom), rand_vec()));
         if ($urandom_range(0, 9) == 0)
            send_item(make_req(FN_ACC, 3'($urandom), rand_vec()));
      end
      for (int i = 0; i < ROWS-1; i++) order[i] = i;
      for (int i = ROWS-2; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i]; order[i] = order[j]; order[j] = tmp;
      end
      for (int i = 0; i < ROWS-1; i++) begin
         v = rand_vec();
         send_item(make_req(FN_EPI, 3'(order[i]), v));
         // repeated rows and a stray early last row now and then
         if ($urandom_range(0, 11) == 0) send_item(make_req(FN_EPI, 3'(order[i]), v));
         if ($urandom_range(0, 39) == 0) send_item(make_req(FN_EPI, 3'(ROWS-1), rand_vec()));
      end
      send_item(make_req(FN_EPI, 3'(ROWS-1), rand_vec()));
      no_idle = 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   // extremes, cancellation and special values at reset settings
   task automatic test_directed_specials();
      vec16_type a, b, nb;
      a = '{32'h3F80_0000, 32'h8000_0000, 32'h7F80_0000, 32'h7FC0_1234, 32'h0000_0001,
            32'h7F7F_FFFF, 32'hBF80_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 32'h0,
            32'h0, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF};
      b = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000,
            32'h7F7F_FFFF, 32'h0000_0001, 32'h007F_FFFF, 32'h4000_0000, 32'hC040_0000,
            32'h3EAA_AAAB, 32'h7FFF_FFFF, 32'h0080_0000, 32'h8080_0000, 32'h4B00_0001,
            32'hFFFF_FFFF};
      for (int i = 0; i < COLS; i++) nb[i] = {~b[i][31], b[i][30:0]};
      send_item(make_req(FN_LOAD_A, 3'd7, a));
      send_item(make_req(FN_ACC, 3'd0, b));
      // negated row: finite lanes cancel exactly to +0
      send_item(make_req(FN_ACC, 3'd5, nb));
      send_item(make_req(FN_UNUSED, 3'd7, b));
      for (int r = 0; r < ROWS; r++) send_item(make_req(FN_EPI, 3'(r), b));
   endtask

   // negative zero beta ignores old c, with an extreme alpha
   task automatic test_neg_zero_beta();
      csr_write(CSR_ALPHA, 32'h7F7F_FFFF);
      csr_write(CSR_BETA, FP_NEG_ZERO);
      send_item(make_req(FN_LOAD_A, 3'd2, rand_vec()));
      send_item(make_req(FN_ACC, 3'd1, rand_vec()));
      send_item(make_req(FN_EPI, 3'd3, rand_vec()));
      send_item(make_req(FN_EPI, 3'd7, rand_vec()));
   endtask

   // random tiles across a spread of alpha and beta settings
   task automatic test_random_tiles();
      logic [31:0] alphas [8];
      logic [31:0] betas [8];
      int          phase_end;
      alphas = '{32'h3F80_0000, 32'h0000_0000, 32'hC000_0000, 32'h0000_0001,
                 32'hFFFF_FFFF, 32'h3E00_0000, 32'h7F80_0000, 32'h4120_0000};
      betas  = '{32'h3F80_0000, 32'hBF00_0000, 32'h0000_0000, 32'h7F7F_FFFF,
                 32'h8000_0001, 32'h7F80_0000, 32'h4000_0000, 32'hFFFF_FFFF};
      for (int ph = 0; ph < 8; ph++) begin
         csr_write(CSR_ALPHA, (ph == 7) ? rand_fp() : alphas[ph]);
         csr_write(CSR_BETA, (ph == 6) ? rand_fp() : betas[ph]);
         phase_end = items_sent + 230;
         while (items_sent < phase_end) begin
            if (ph == 2 && items_sent + 100 > phase_end && hold_req == 0) begin
               // receiver stops for a long stretch while items keep coming
               hold_req = 1;
            end
            if (ph == 4 && items_sent + 115 > phase_end && items_sent + 100 < phase_end) begin
               while (row_results_q.size() != 0) @(negedge clock);
            end
            run_tile();
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver and checks

   // receiver stalls, plus a long hold-off requested by the test
   initial begin
      int stall_left;
      int hold_left;
      int hold_seen;
      stall_left = 0;
      hold_left  = 0;
      hold_seen  = 0;
      rsp_ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else if (no_idle) begin
            rsp_ready = 1'b1;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if ($urandom_range(0, 99) < 15)
               stall_left = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60)
                                                           : $urandom_range(1, 3);
         end
      end
   end

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got, ref bit bad);
      if (want !== got) begin
         bad = 1'b1;
         if (err_count < 10)
            $display("mismatch on %s at row %0d: expected %h, got %h",
                     name, rsp_data.out_row, want, got);
         err_count++;
      end
   endtask

   // compare each rsp transfer with the oldest predicted row
   initial begin
      rsp_type want;
      bit      bad;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            transfers++;
            if (row_results_q.size() == 0) begin
               if (err_count < 10) $display("unexpected result row %0d", rsp_data.out_row);
               err_count++;
            end else begin
               want = row_results_q.pop_front();
               bad  = 1'b0;
               check_field("out_row", 64'(want.out_row), 64'(rsp_data.out_row), bad);
               check_field("out_word0", want.out_word0, rsp_data.out_word0, bad);
               check_field("out_word1", want.out_word1, rsp_data.out_word1, bad);
               check_field("out_word2", want.out_word2, rsp_data.out_word2, bad);
               check_field("out_word3", want.out_word3, rsp_data.out_word3, bad);
               check_field("out_word4", want.out_word4, rsp_data.out_word4, bad);
               check_field("out_word5", want.out_word5, rsp_data.out_word5, bad);
               check_field("out_word6", want.out_word6, rsp_data.out_word6, bad);
               check_field("out_word7", want.out_word7, rsp_data.out_word7, bad);
               check_field("tile_done", 64'(want.tile_done), 64'(rsp_data.tile_done), bad);
               rows_checked++;
            end
         end
      end
   end

   // watchdog: too long without any transfer ends the run
   initial begin
      int idle_cycles;
      int last_seen;
      idle_cycles = 0;
      last_seen   = 0;
      forever begin
         @(negedge clock);
         if (transfers == last_seen) idle_cycles++;
         else idle_cycles = 0;
         last_seen = transfers;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout with %0d rows still expected", row_results_q.size());
            $display("testbench: errors");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      reset      = 1'b1;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_valid  = 1'b0;
      csr_index  = CSR_ALPHA;
      csr_data   = '0;
      no_idle    = 1'b0;
      hold_req   = 0;
      err_count  = 0;
      transfers  = 0;
      items_sent = 0;
      rows_checked = 0;
      alpha_m    = ALPHA_RESET;
      beta_m     = BETA_RESET;
      for (int r = 0; r < ROWS; r++) a_col_m[r] = 32'h0;
      for (int i = 0; i < ROWS*COLS; i++) acc_m[i] = 32'h0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_specials();
      test_neg_zero_beta();
      test_random_tiles();

      while (row_results_q.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      $display("covered %0d items and %0d returned rows over 18 register settings",
               items_sent, rows_checked);
      $display("including fp specials, cancellation, a long receiver hold-off and a drain");
      if (err_count == 0 && row_results_q.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("%0d failures", err_count);
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
